>>> hdl/mpfb_pkg.sv
// ----------------------------------------------------------------------------
// mpfb_pkg
// Shared types, constants and byte/CRC helpers for the motor position
// frame builder.
// ----------------------------------------------------------------------------
package mpfb_pkg;

	// frame layout
	localparam int FrameLen = 23;
	localparam int CrcSpan  = 21;
	localparam int IdxW     = $clog2(FrameLen);

	localparam logic [IdxW-1:0] LastIdx   = IdxW'(FrameLen - 1);
	localparam logic [IdxW-1:0] CrcLoIdx  = IdxW'(CrcSpan);
	localparam logic [IdxW-1:0] CrcHiIdx  = IdxW'(CrcSpan + 1);

	// fixed header bytes
	localparam logic [7:0] FuncWriteMulti = 8'h10;
	localparam logic [7:0] RegAddrHi      = 8'h00;
	localparam logic [7:0] RegAddrLo      = 8'hF6;
	localparam logic [7:0] RegCountHi     = 8'h00;
	localparam logic [7:0] RegCountLo     = 8'h07;
	localparam logic [7:0] DataByteCount  = 8'h0E;

	// crc-16/modbus
	localparam logic [15:0] CrcInit = 16'hFFFF;
	localparam logic [15:0] CrcPoly = 16'hA001;

	// position range thresholds
	localparam int RangeLow  = 82 * 800;
	localparam int RangeHigh = 160 * 800;

	// range codes
	localparam logic [1:0] RangeNone = 2'd0;
	localparam logic [1:0] RangeMid  = 2'd1;
	localparam logic [1:0] RangeOver = 2'd2;

	// motor addresses
	localparam logic [7:0] MotorOne   = 8'd1;
	localparam logic [7:0] MotorTwo   = 8'd2;
	localparam logic [7:0] MotorThree = 8'd3;

	// config register indexes
	localparam logic [1:0] RegGearOne   = 2'd0;
	localparam logic [1:0] RegGearTwo   = 2'd1;
	localparam logic [1:0] RegGearThree = 2'd2;

	localparam logic [9:0] GearOneReset   = 10'd310;
	localparam logic [9:0] GearTwoReset   = 10'd800;
	localparam logic [9:0] GearThreeReset = 10'd100;

	localparam int QueueDepthDefault = 2;

	// one classified command, payload already zeroed for bad addresses
	typedef struct packed {
		logic [7:0]  addr;
		logic        dir;
		logic [15:0] accel;
		logic [15:0] decel;
		logic [15:0] speed;
		logic [15:0] mag;
		logic [1:0]  range;
		logic        kind;
	} cmd_t;

	// frame byte at a data/header offset (crc bytes handled elsewhere)
	function automatic logic [7:0] frame_byte_at(cmd_t e, logic [IdxW-1:0] idx);
		logic [7:0] b;
		case (idx)
			5'd0:    b = e.addr;
			5'd1:    b = FuncWriteMulti;
			5'd2:    b = RegAddrHi;
			5'd3:    b = RegAddrLo;
			5'd4:    b = RegCountHi;
			5'd5:    b = RegCountLo;
			5'd6:    b = DataByteCount;
			5'd8:    b = {7'd0, e.dir};
			5'd9:    b = e.accel[15:8];
			5'd10:   b = e.accel[7:0];
			5'd11:   b = e.decel[15:8];
			5'd12:   b = e.decel[7:0];
			5'd13:   b = e.speed[15:8];
			5'd14:   b = e.speed[7:0];
			5'd15:   b = e.mag[15:8];
			5'd16:   b = e.mag[7:0];
			5'd18:   b = {6'd0, e.range};
			5'd19:   b = {7'd0, e.kind};
			default: b = 8'd0;
		endcase
		return b;
	endfunction

	// fold one byte into the crc, lsb first
	function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
		end
		return c;
	endfunction

endpackage

>>> hdl/mpfb_front.sv
// ----------------------------------------------------------------------------
// mpfb_front
// Gear scale registers, command accept and classification: selects the
// motor scale, multiplies the angle and builds one queued command.
// ----------------------------------------------------------------------------
module mpfb_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                kind,
	input  logic [7:0]          motor_address,
	input  logic [15:0]         accel_rate,
	input  logic [15:0]         decel_rate,
	input  logic [15:0]         top_speed,
	input  logic signed [15:0]  target_angle,
	input  logic                wr_en,
	input  logic [1:0]          wr_index,
	input  logic [9:0]          wr_data,
	output logic                push,
	output mpfb_pkg::cmd_t      push_data,
	input  logic                q_full
);

	logic [9:0] gear_one_q, gear_two_q, gear_three_q;

	logic               vld_s1, vld_s2;
	logic               kind_s1, kind_s2;
	logic [7:0]         addr_s1, addr_s2;
	logic [15:0]        accel_s1, accel_s2;
	logic [15:0]        decel_s1, decel_s2;
	logic [15:0]        speed_s1, speed_s2;
	logic signed [15:0] angle_s1;
	logic [9:0]         scale_s1;
	logic signed [26:0] product_s2;

	logic        accept, s2_free, s1_move, addr_ok;
	logic [9:0]  scale_sel;
	logic [15:0] speed10;
	logic [26:0] abs_val;
	logic [25:0] mag;

	// gear scale registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gear_one_q   <= mpfb_pkg::GearOneReset;
			gear_two_q   <= mpfb_pkg::GearTwoReset;
			gear_three_q <= mpfb_pkg::GearThreeReset;
		end else if (wr_en) begin
			unique case (wr_index)
				mpfb_pkg::RegGearOne:   gear_one_q   <= wr_data;
				mpfb_pkg::RegGearTwo:   gear_two_q   <= wr_data;
				mpfb_pkg::RegGearThree: gear_three_q <= wr_data;
				default: ;
			endcase
		end
	end

	// pipeline flow control
	assign push    = vld_s2 && !q_full;
	assign s2_free = !vld_s2 || push;
	assign s1_move = vld_s1 && s2_free;
	assign busy    = vld_s1 && !s2_free;
	assign accept  = start && !busy;

	// motor scale lookup
	always_comb begin
		addr_ok   = 1'b1;
		scale_sel = 10'd0;
		unique case (motor_address)
			mpfb_pkg::MotorOne:   scale_sel = gear_one_q;
			mpfb_pkg::MotorTwo:   scale_sel = gear_two_q;
			mpfb_pkg::MotorThree: scale_sel = gear_three_q;
			default:              addr_ok = 1'b0;
		endcase
	end

	assign speed10 = 16'({top_speed, 3'b000} + {2'b00, top_speed, 1'b0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (accept)
				vld_s1 <= 1'b1;
			else if (s1_move)
				vld_s1 <= 1'b0;
			if (s2_free)
				vld_s2 <= vld_s1;
		end
	end

	// stage 1: register the item, payload zeroed for unknown motors
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= kind;
			addr_s1  <= addr_ok ? motor_address : 8'd0;
			accel_s1 <= addr_ok ? accel_rate : 16'd0;
			decel_s1 <= addr_ok ? decel_rate : 16'd0;
			speed_s1 <= addr_ok ? speed10 : 16'd0;
			angle_s1 <= target_angle;
			scale_s1 <= scale_sel;
		end
	end

	// stage 2: scaled position
	always_ff @(posedge clk) begin
		if (s1_move) begin
			kind_s2    <= kind_s1;
			addr_s2    <= addr_s1;
			accel_s2   <= accel_s1;
			decel_s2   <= decel_s1;
			speed_s2   <= speed_s1;
			product_s2 <= angle_s1 * $signed({1'b0, scale_s1});
		end
	end

	// magnitude and range code
	assign abs_val = product_s2[26] ? 27'(-product_s2) : 27'(product_s2);
	assign mag     = abs_val[25:0];

	always_comb begin
		push_data       = '0;
		push_data.addr  = addr_s2;
		push_data.dir   = product_s2[26];
		push_data.accel = accel_s2;
		push_data.decel = decel_s2;
		push_data.speed = speed_s2;
		push_data.mag   = mag[15:0];
		push_data.kind  = kind_s2;
		if (mag > 26'(mpfb_pkg::RangeHigh))
			push_data.range = mpfb_pkg::RangeOver;
		else if (mag >= 26'(mpfb_pkg::RangeLow))
			push_data.range = mpfb_pkg::RangeMid;
		else
			push_data.range = mpfb_pkg::RangeNone;
	end

endmodule

>>> hdl/mpfb_queue.sv
// ----------------------------------------------------------------------------
// mpfb_queue
// Small command queue between the classifier and the byte serializer.
// ----------------------------------------------------------------------------
module mpfb_queue #(
	parameter int Depth = mpfb_pkg::QueueDepthDefault
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mpfb_pkg::cmd_t push_data,
	output logic           full,
	input  logic           pop,
	output mpfb_pkg::cmd_t pop_data,
	output logic           not_empty
);

	localparam int PtrW = $clog2(Depth);
	localparam int CntW = $clog2(Depth + 1);

	mpfb_pkg::cmd_t entry_q [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full      = (count_q == CntW'(Depth));
	assign not_empty = (count_q != '0);
	assign pop_data  = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	// no write into a full queue without a pop, no read from an empty one
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop)) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !not_empty)) else $error("queue underflow");

endmodule

>>> hdl/mpfb_back.sv
// ----------------------------------------------------------------------------
// mpfb_back
// Byte serializer: walks one queued command through its 23 frame bytes,
// folding the first 21 into the crc and appending it low byte first.
// ----------------------------------------------------------------------------
module mpfb_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           not_empty,
	input  mpfb_pkg::cmd_t pop_data,
	output logic           pop,
	output logic           strobe,
	output logic [7:0]     frame_byte,
	output logic           last_byte
);

	mpfb_pkg::cmd_t             cmd_q;
	logic                       active_q;
	logic [mpfb_pkg::IdxW-1:0]  cnt_q;
	logic [15:0]                crc_q;
	logic                       strobe_q, last_q;
	logic [7:0]                 byte_q;

	logic       at_last;
	logic [7:0] cur_byte;

	assign at_last = (cnt_q == mpfb_pkg::LastIdx);
	assign pop     = not_empty && (!active_q || at_last);

	// current byte of the frame
	always_comb begin
		if (cnt_q == mpfb_pkg::CrcLoIdx)
			cur_byte = crc_q[7:0];
		else if (cnt_q == mpfb_pkg::CrcHiIdx)
			cur_byte = crc_q[15:8];
		else
			cur_byte = mpfb_pkg::frame_byte_at(cmd_q, cnt_q);
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			strobe_q <= active_q;
			last_q   <= active_q && at_last;
			if (pop) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (active_q) begin
				if (at_last)
					active_q <= 1'b0;
				else
					cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// command, crc and output byte
	always_ff @(posedge clk) begin
		byte_q <= cur_byte;
		if (pop) begin
			cmd_q <= pop_data;
			crc_q <= mpfb_pkg::CrcInit;
		end else if (active_q && cnt_q < mpfb_pkg::CrcLoIdx) begin
			crc_q <= mpfb_pkg::crc_byte(crc_q, cur_byte);
		end
	end

	assign strobe     = strobe_q;
	assign frame_byte = byte_q;
	assign last_byte  = last_q;

	// frame bytes come out back to back and the counter stays in range
	a_last_strobed: assert property (@(posedge clk) disable iff (!arst_n)
		last_byte |-> strobe) else $error("last byte without strobe");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (cnt_q <= mpfb_pkg::LastIdx)) else $error("byte index out of range");
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last_byte) |=> strobe) else $error("gap inside a frame");

endmodule

>>> hdl/motor_position_frame_builder_top.sv
// ----------------------------------------------------------------------------
// motor_position_frame_builder_top
// Builds a 23-byte Modbus RTU write-multiple-registers frame with CRC-16
// for each motor position command and streams it out a byte at a time.
// ----------------------------------------------------------------------------
// Each command accepted on start (while busy is low) becomes one frame of
// 23 bytes, presented one per clock with strobe high and last_byte marking
// the CRC high byte; the receiver cannot stall, so bytes must be taken as
// they appear. The byte serializer sends all 23 bytes of one command before
// it takes the next, with frames of consecutive commands following with no
// gap. A two-stage classifier and a small command queue (QueueDepth
// entries) sit in front of the serializer, so further commands are taken
// while a frame is still going out; busy rises only once the queue and the
// classifier stages are all holding commands.
// Gear scale registers are written through wr_en/wr_index/wr_data and
// should only change while no command is in flight.
// ----------------------------------------------------------------------------
module motor_position_frame_builder_top #(
	parameter int QueueDepth = mpfb_pkg::QueueDepthDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               kind,
	input  logic [7:0]         motor_address,
	input  logic [15:0]        accel_rate,
	input  logic [15:0]        decel_rate,
	input  logic [15:0]        top_speed,
	input  logic signed [15:0] target_angle,
	input  logic               wr_en,
	input  logic [1:0]         wr_index,
	input  logic [9:0]         wr_data,
	output logic               strobe,
	output logic [7:0]         frame_byte,
	output logic               last_byte
);

	logic           push, q_full, pop, q_not_empty;
	mpfb_pkg::cmd_t push_data, pop_data;

	// classifier
	mpfb_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.kind          (kind),
		.motor_address (motor_address),
		.accel_rate    (accel_rate),
		.decel_rate    (decel_rate),
		.top_speed     (top_speed),
		.target_angle  (target_angle),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.push          (push),
		.push_data     (push_data),
		.q_full        (q_full)
	);

	// command queue
	mpfb_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.not_empty (q_not_empty)
	);

	// byte serializer
	mpfb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.not_empty  (q_not_empty),
		.pop_data   (pop_data),
		.pop        (pop),
		.strobe     (strobe),
		.frame_byte (frame_byte),
		.last_byte  (last_byte)
	);

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the motor position frame builder. Commands go in
// on the start/busy port and each one is predicted as a full 23-byte frame
// (header, data bytes, crc-16 low then high). Every strobed byte is checked
// in order against the prediction, over several gear scale settings.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] RegBeyondList = 2'd3;
	localparam int CycleLimit = 200000;
	localparam int TailCycles = 40;

	// one motor command as driven on the input ports
	typedef struct {
		logic              kind;
		logic [7:0]        addr;
		logic [15:0]       accel;
		logic [15:0]       decel;
		logic [15:0]       speed;
		logic signed [15:0] angle;
	} motor_cmd_t;

	// one predicted frame byte
	typedef struct {
		logic [7:0] value;
		logic       last;
	} frame_octet_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic               kind = 1'b0;
	logic [7:0]         motor_address = 8'd0;
	logic [15:0]        accel_rate = 16'd0;
	logic [15:0]        decel_rate = 16'd0;
	logic [15:0]        top_speed = 16'd0;
	logic signed [15:0] target_angle = 16'sd0;
	logic               wr_en = 1'b0;
	logic [1:0]         wr_index = 2'd0;
	logic [9:0]         wr_data = 10'd0;
	logic               strobe;
	logic [7:0]         frame_byte;
	logic               last_byte;

	motor_cmd_t   cmd_pending[$];
	frame_octet_t expected_frame_bytes[$];
	motor_cmd_t   cur_cmd;
	logic [9:0]   gear_scale [3];
	bit           have_cmd = 1'b0;
	bit           cmd_taken = 1'b0;
	bit           gaps_off = 1'b0;
	int           gap_left = 0;
	int           errors = 0;
	int           cycle_count = 0;

	motor_position_frame_builder_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.kind          (kind),
		.motor_address (motor_address),
		.accel_rate    (accel_rate),
		.decel_rate    (decel_rate),
		.top_speed     (top_speed),
		.target_angle  (target_angle),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.strobe        (strobe),
		.frame_byte    (frame_byte),
		.last_byte     (last_byte)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CycleLimit) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// predict the whole frame of one command and queue its bytes
	function automatic void predict_frame(motor_cmd_t c);
		logic [7:0]   f [mpfb_pkg::FrameLen];
		logic [9:0]   scale;
		logic [31:0]  mag;
		logic [31:0]  speed_x10;
		logic [15:0]  crc;
		longint       pos;
		bit           addr_ok;
		frame_octet_t o;
		for (int i = 0; i < mpfb_pkg::FrameLen; i++)
			f[i] = 8'd0;
		f[1]  = mpfb_pkg::FuncWriteMulti;
		f[2]  = mpfb_pkg::RegAddrHi;
		f[3]  = mpfb_pkg::RegAddrLo;
		f[4]  = mpfb_pkg::RegCountHi;
		f[5]  = mpfb_pkg::RegCountLo;
		f[6]  = mpfb_pkg::DataByteCount;
		f[19] = {7'd0, c.kind};
		addr_ok = 1'b1;
		scale = 10'd0;
		case (c.addr)
			mpfb_pkg::MotorOne:   scale = gear_scale[mpfb_pkg::RegGearOne];
			mpfb_pkg::MotorTwo:   scale = gear_scale[mpfb_pkg::RegGearTwo];
			mpfb_pkg::MotorThree: scale = gear_scale[mpfb_pkg::RegGearThree];
			default:              addr_ok = 1'b0;
		endcase
		// bad address leaves the payload zeroed
		if (addr_ok) begin
			pos = longint'(c.angle) * longint'(scale);
			mag = (pos < 0) ? 32'(-pos) : 32'(pos);
			speed_x10 = 32'(c.speed) * 32'd10;
			f[0]  = c.addr;
			f[8]  = (pos < 0) ? 8'd1 : 8'd0;
			f[9]  = c.accel[15:8];
			f[10] = c.accel[7:0];
			f[11] = c.decel[15:8];
			f[12] = c.decel[7:0];
			f[13] = speed_x10[15:8];
			f[14] = speed_x10[7:0];
			f[15] = mag[15:8];
			f[16] = mag[7:0];
			if (mag >= mpfb_pkg::RangeLow && mag <= mpfb_pkg::RangeHigh)
				f[18] = {6'd0, mpfb_pkg::RangeMid};
			else if (mag > mpfb_pkg::RangeHigh)
				f[18] = {6'd0, mpfb_pkg::RangeOver};
		end
		// reflected crc over header and data, lsb first
		crc = mpfb_pkg::CrcInit;
		for (int i = 0; i < mpfb_pkg::CrcSpan; i++) begin
			crc[7:0] = crc[7:0] ^ f[i];
			for (int b = 0; b < 8; b++) begin
				if (crc[0])
					crc = {1'b0, crc[15:1]} ^ mpfb_pkg::CrcPoly;
				else
					crc = {1'b0, crc[15:1]};
			end
		end
		f[mpfb_pkg::CrcSpan]     = crc[7:0];
		f[mpfb_pkg::CrcSpan + 1] = crc[15:8];
		for (int i = 0; i < mpfb_pkg::FrameLen; i++) begin
			o.value = f[i];
			o.last  = (i == mpfb_pkg::FrameLen - 1);
			expected_frame_bytes.push_back(o);
		end
	endfunction

	function automatic motor_cmd_t make_cmd(logic k, logic [7:0] a, logic [15:0] acc,
			logic [15:0] dec, logic [15:0] spd, logic signed [15:0] ang);
		motor_cmd_t c;
		c.kind  = k;
		c.addr  = a;
		c.accel = acc;
		c.decel = dec;
		c.speed = spd;
		c.angle = ang;
		return c;
	endfunction

	// mostly valid motors, angles spread over full range and threshold region
	function automatic motor_cmd_t random_cmd();
		motor_cmd_t c;
		c.kind  = 1'($urandom_range(0, 1));
		c.addr  = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
		                                      : 8'($urandom_range(1, 3));
		c.accel = 16'($urandom);
		c.decel = 16'($urandom);
		c.speed = 16'($urandom);
		case ($urandom_range(0, 2))
			0:       c.angle = 16'($urandom);
			1:       c.angle = 16'($urandom_range(0, 400) - 200);
			default: c.angle = 16'($urandom_range(0, 16) - 8);
		endcase
		return c;
	endfunction

	task automatic queue_random(int n);
		for (int i = 0; i < n; i++)
			cmd_pending.push_back(random_cmd());
	endtask

	// gear scale write, mirrored into the local copy
	task automatic write_gear(logic [1:0] idx, logic [9:0] val);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		if (idx != RegBeyondList)
			gear_scale[idx] = val;
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	// wait until every command went in and every frame came out
	task automatic wait_drained();
		do
			@(negedge clk);
		while (cmd_pending.size() != 0 || have_cmd || expected_frame_bytes.size() != 0);
	endtask

	// feed the next pending item to the command port
	always @(negedge clk) begin
		if (arst_n) begin
			if (cmd_taken) begin
				cmd_taken = 1'b0;
				have_cmd  = 1'b0;
				if (!gaps_off && $urandom_range(0, 2) == 0)
					gap_left = $urandom_range(1, 5);
			end
			if (gap_left > 0) begin
				gap_left--;
			end else if (!have_cmd && cmd_pending.size() != 0) begin
				cur_cmd  = cmd_pending.pop_front();
				have_cmd = 1'b1;
				kind          <= cur_cmd.kind;
				motor_address <= cur_cmd.addr;
				accel_rate    <= cur_cmd.accel;
				decel_rate    <= cur_cmd.decel;
				top_speed     <= cur_cmd.speed;
				target_angle  <= cur_cmd.angle;
			end
			start <= have_cmd;
		end
	end

	// check strobed bytes, predict on accepted commands
	always @(posedge clk) begin : monitor
		frame_octet_t want;
		if (arst_n) begin
			if (strobe) begin
				if (expected_frame_bytes.size() == 0) begin
					$error("frame_byte 0x%02h (last_byte %0b) with no frame pending",
						frame_byte, last_byte);
					errors++;
				end else begin
					want = expected_frame_bytes.pop_front();
					if (frame_byte !== want.value) begin
						$error("frame_byte: expected 0x%02h, actual 0x%02h",
							want.value, frame_byte);
						errors++;
					end
					if (last_byte !== want.last) begin
						$error("last_byte: expected %0b, actual %0b", want.last, last_byte);
						errors++;
					end
				end
			end
			if (start && !busy) begin
				predict_frame(cur_cmd);
				cmd_taken = 1'b1;
			end
		end
	end

	// phases: directed at reset scales, then random over several scale sets
	initial begin
		gear_scale[mpfb_pkg::RegGearOne]   = mpfb_pkg::GearOneReset;
		gear_scale[mpfb_pkg::RegGearTwo]   = mpfb_pkg::GearTwoReset;
		gear_scale[mpfb_pkg::RegGearThree] = mpfb_pkg::GearThreeReset;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// field extremes and range code boundaries at reset scales
		cmd_pending.push_back(make_cmd(1'b0, mpfb_pkg::MotorOne,
			16'h0000, 16'h0000, 16'h0000, 16'sd0));
		cmd_pending.push_back(make_cmd(1'b1, mpfb_pkg::MotorOne,
			16'hFFFF, 16'hFFFF, 16'hFFFF, 16'sd32767));
		cmd_pending.push_back(make_cmd(1'b0, mpfb_pkg::MotorOne,
			16'h00FF, 16'hFF00, 16'd6553, -16'sd32768));
		cmd_pending.push_back(make_cmd(1'b1, mpfb_pkg::MotorTwo,
			16'h1234, 16'h5678, 16'd6554, 16'sd81));
		cmd_pending.push_back(make_cmd(1'b0, mpfb_pkg::MotorTwo,
			16'hA5A5, 16'h5A5A, 16'd1000, 16'sd82));
		cmd_pending.push_back(make_cmd(1'b1, mpfb_pkg::MotorTwo,
			16'h8000, 16'h0001, 16'd1, 16'sd160));
		cmd_pending.push_back(make_cmd(1'b0, mpfb_pkg::MotorTwo,
			16'h0001, 16'h8000, 16'd3000, 16'sd161));
		cmd_pending.push_back(make_cmd(1'b1, mpfb_pkg::MotorTwo,
			16'h7FFF, 16'h7FFF, 16'd250, -16'sd82));
		cmd_pending.push_back(make_cmd(1'b0, mpfb_pkg::MotorTwo,
			16'hFFFF, 16'h0000, 16'd65535, -16'sd161));
		cmd_pending.push_back(make_cmd(1'b1, mpfb_pkg::MotorTwo,
			16'h0F0F, 16'hF0F0, 16'd12, -16'sd1));
		cmd_pending.push_back(make_cmd(1'b0, mpfb_pkg::MotorThree,
			16'h3C3C, 16'hC3C3, 16'd65535, -16'sd1));
		cmd_pending.push_back(make_cmd(1'b1, mpfb_pkg::MotorThree,
			16'h0000, 16'hFFFF, 16'd0, 16'sd32767));
		// invalid motor addresses: payload zeroed, absolute flag kept
		cmd_pending.push_back(make_cmd(1'b1, 8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, -16'sd32768));
		cmd_pending.push_back(make_cmd(1'b0, 8'd4, 16'h1111, 16'h2222, 16'h3333, 16'sd500));
		cmd_pending.push_back(make_cmd(1'b1, 8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'sd32767));
		wait_drained();

		// scale zero, largest scale, smallest scale; out-of-list index ignored
		write_gear(mpfb_pkg::RegGearOne, 10'd0);
		write_gear(mpfb_pkg::RegGearTwo, 10'd1023);
		write_gear(mpfb_pkg::RegGearThree, 10'd1);
		write_gear(RegBeyondList, 10'h2AA);
		cmd_pending.push_back(make_cmd(1'b0, mpfb_pkg::MotorOne,
			16'h4321, 16'h8765, 16'd77, -16'sd5));
		cmd_pending.push_back(make_cmd(1'b1, mpfb_pkg::MotorTwo,
			16'hFFFF, 16'h0000, 16'd9, -16'sd32768));
		cmd_pending.push_back(make_cmd(1'b0, mpfb_pkg::MotorThree,
			16'h0000, 16'hFFFF, 16'd9, -16'sd32768));
		queue_random(30);
		wait_drained();

		// random scales
		write_gear(mpfb_pkg::RegGearOne, 10'($urandom_range(1, 1023)));
		write_gear(mpfb_pkg::RegGearTwo, 10'($urandom_range(1, 1023)));
		write_gear(mpfb_pkg::RegGearThree, 10'($urandom_range(1, 1023)));
		write_gear(RegBeyondList, 10'($urandom_range(0, 1023)));
		queue_random(30);
		wait_drained();

		// back-to-back commands, no idling
		write_gear(mpfb_pkg::RegGearOne, 10'd1023);
		write_gear(mpfb_pkg::RegGearTwo, 10'd800);
		write_gear(mpfb_pkg::RegGearThree, 10'd0);
		gaps_off = 1'b1;
		queue_random(40);
		wait_drained();

		// catch stray bytes after the last frame
		repeat (TailCycles) @(posedge clk);
		if (errors == 0 && expected_frame_bytes.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

>>> motor_position_frame_builder_top.f
hdl/mpfb_pkg.sv
hdl/mpfb_front.sv
hdl/mpfb_queue.sv
hdl/mpfb_back.sv
hdl/motor_position_frame_builder_top.sv
tb/sv/tb.sv
